// ===== hw/rtl/serial_command_frame_parser_defines.svh =====
// ----------------------------------------------------------------------------
// Serial command frame parser assertion macros
// Shared assertion forms for the checker, clocked on clk_i and disabled
// while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SERIAL_COMMAND_FRAME_PARSER_DEFINES_SVH
`define SERIAL_COMMAND_FRAME_PARSER_DEFINES_SVH

// Plain property check.
`define SCFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication check: whenever ante holds, cons must hold in the same cycle.
`define SCFP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/scfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial command frame parser package
// Shared constants, result kinds and controller/datapath interface types.
// ----------------------------------------------------------------------------
package scfp_pkg;

  localparam int ByteW         = 8;
  localparam int LenFieldW     = 6;
  localparam int MaxPayloadDef = 63;

  localparam logic [ByteW-1:0] StartByte   = 8'hED;
  localparam logic [ByteW-1:0] SyncByte    = 8'h01;
  localparam logic [ByteW-1:0] TrailerByte = 8'hEE;

  typedef enum logic [1:0] {
    KIND_READ = 2'd0,
    KIND_HDR  = 2'd1,
    KIND_PAY  = 2'd2,
    KIND_ERR  = 2'd3
  } kind_e;

  typedef struct packed {
    logic  cap_cmd;
    logic  load_len;
    logic  clr_cnt;
    logic  take_byte;
    logic  cap_sum;
    logic  out_load;
    kind_e out_kind;
  } cmd_t;

  typedef struct packed {
    logic is_start;
    logic is_sync;
    logic is_trailer;
    logic is_zero;
    logic too_long;
    logic body_last;
    logic sum_ok;
    logic pay_last;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/serial_command_frame_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial command frame parser
// Recognizes command frames in a stream of received serial bytes.
// ----------------------------------------------------------------------------
// Usage: received bytes enter on rx_byte_i, one request per in_valid_i/in_stall_o
// handshake. Results leave on the output channel, one request per result, with
// kind_o, command_o, payload_length_o, payload_byte_o and last_o.
// While a frame is parsed, every byte is taken in the cycle it is offered.
// After a frame's trailer byte, the controller enters a result state, which then
// loads the first result into the output register. A write frame with L payload
// bytes then delivers its header and payload results at one per cycle unless the
// receiver stalls, 1 + L results in all. Read and checksum-error frames give
// one result. The input is stalled while results are being loaded and is taken
// again once the final result sits in the output register.
// Reset clears the parser back to hunting for a start byte and empties the
// output register. When the receiver stalls, the current result holds steady
// and result loading waits, which in turn holds off new input bytes.
// ----------------------------------------------------------------------------
module serial_command_frame_parser import scfp_pkg::*; #(
  parameter int MaxPayload = MaxPayloadDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [ByteW-1:0]     rx_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           kind_o,
  output logic [ByteW-1:0]     command_o,
  output logic [LenFieldW-1:0] payload_length_o,
  output logic [ByteW-1:0]     payload_byte_o,
  output logic                 last_o
);

  cmd_t cmd;
  sts_t sts;

  scfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  scfp_dp #(
    .MaxPayload (MaxPayload)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rx_byte_i        (rx_byte_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .command_o        (command_o),
    .payload_length_o (payload_length_o),
    .payload_byte_o   (payload_byte_o),
    .last_o           (last_o)
  );

endmodule

// ===== hw/rtl/scfp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial command frame parser controller
// Frame state machine that steers the datapath and the request handshakes.
// ----------------------------------------------------------------------------
module scfp_ctrl import scfp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [12:0] {
    ST_HUNT   = 13'b0000000000001,
    ST_SYNC   = 13'b0000000000010,
    ST_CMD    = 13'b0000000000100,
    ST_LEN    = 13'b0000000001000,
    ST_RSUM   = 13'b0000000010000,
    ST_RTRL   = 13'b0000000100000,
    ST_BODY   = 13'b0000001000000,
    ST_WSUM   = 13'b0000010000000,
    ST_WTRL   = 13'b0000100000000,
    ST_RDOUT  = 13'b0001000000000,
    ST_ERROUT = 13'b0010000000000,
    ST_HDR    = 13'b0100000000000,
    ST_PAY    = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.out_kind = KIND_READ;
    in_stall_o = 1'b1;
    case (state_q)
      ST_HUNT: begin
        in_stall_o = 1'b0;
        if (in_valid_i && sts_i.is_start) begin
          state_d = ST_SYNC;
        end
      end
      ST_SYNC: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = sts_i.is_sync ? ST_CMD : ST_HUNT;
        end
      end
      ST_CMD: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.cap_cmd = 1'b1;
          state_d = ST_LEN;
        end
      end
      ST_LEN: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_len = 1'b1;
          cmd_o.clr_cnt  = 1'b1;
          if (sts_i.too_long) begin
            state_d = ST_HUNT;
          end else if (sts_i.is_zero) begin
            state_d = ST_RSUM;
          end else begin
            state_d = ST_BODY;
          end
        end
      end
      ST_RSUM: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = sts_i.is_zero ? ST_RTRL : ST_HUNT;
        end
      end
      ST_RTRL: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = sts_i.is_trailer ? ST_RDOUT : ST_HUNT;
        end
      end
      ST_BODY: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.take_byte = 1'b1;
          if (sts_i.body_last) begin
            state_d = ST_WSUM;
          end
        end
      end
      ST_WSUM: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.cap_sum = 1'b1;
          state_d = ST_WTRL;
        end
      end
      ST_WTRL: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.clr_cnt = 1'b1;
          if (!sts_i.sum_ok) begin
            state_d = ST_ERROUT;
          end else if (sts_i.is_trailer) begin
            state_d = ST_HDR;
          end else begin
            state_d = ST_HUNT;
          end
        end
      end
      ST_RDOUT: begin
        cmd_o.out_kind = KIND_READ;
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_HUNT;
        end
      end
      ST_ERROUT: begin
        cmd_o.out_kind = KIND_ERR;
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_HUNT;
        end
      end
      ST_HDR: begin
        cmd_o.out_kind = KIND_HDR;
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_PAY;
        end
      end
      ST_PAY: begin
        cmd_o.out_kind = KIND_PAY;
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (sts_i.pay_last) begin
            state_d = ST_HUNT;
          end
        end
      end
      default: begin
        state_d = ST_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/scfp_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial command frame parser datapath
// Frame fields, payload sum, payload store and the result output register.
// ----------------------------------------------------------------------------
module scfp_dp import scfp_pkg::*; #(
  parameter int MaxPayload = MaxPayloadDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [ByteW-1:0]     rx_byte_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           kind_o,
  output logic [ByteW-1:0]     command_o,
  output logic [LenFieldW-1:0] payload_length_o,
  output logic [ByteW-1:0]     payload_byte_o,
  output logic                 last_o
);

  localparam int LenW = $clog2(MaxPayload + 1);
  localparam int IdxW = (MaxPayload > 1) ? $clog2(MaxPayload) : 1;

  logic [ByteW-1:0]     mem [MaxPayload];
  logic [ByteW-1:0]     rd_q;
  logic [ByteW-1:0]     cmd_q;
  logic [LenFieldW-1:0] len_q;
  logic [ByteW-1:0]     sum_q, sum_d;
  logic [ByteW-1:0]     rsum_q;
  logic [LenW-1:0]      cnt_q, cnt_d, cnt_inc;
  logic                 out_valid_q, out_valid_d;
  logic [1:0]           kind_q;
  logic [ByteW-1:0]     ocmd_q;
  logic [LenFieldW-1:0] olen_q;
  logic [ByteW-1:0]     obyte_q;
  logic                 olast_q;
  logic                 last_d;
  logic                 out_free;

  assign cnt_inc  = cnt_q + 1'b1;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.clr_cnt) begin
      cnt_d = '0;
    end else if (cmd_i.take_byte || (cmd_i.out_load && cmd_i.out_kind == KIND_PAY)) begin
      cnt_d = cnt_inc;
    end
  end

  always_comb begin
    sum_d = sum_q;
    if (cmd_i.load_len) begin
      sum_d = '0;
    end else if (cmd_i.take_byte) begin
      sum_d = sum_q + rx_byte_i;
    end
  end

  always_comb begin
    case (cmd_i.out_kind)
      KIND_READ: last_d = 1'b1;
      KIND_ERR:  last_d = 1'b1;
      KIND_HDR:  last_d = (len_q == '0);
      KIND_PAY:  last_d = (cnt_inc == LenW'(len_q));
      default:   last_d = 1'b1;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_byte) begin
      mem[cnt_q[IdxW-1:0]] <= rx_byte_i;
    end
    if (cnt_d < LenW'(MaxPayload)) begin
      rd_q <= mem[cnt_d[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    if (cmd_i.cap_cmd) begin
      cmd_q <= rx_byte_i;
    end
    if (cmd_i.load_len) begin
      len_q <= rx_byte_i[LenFieldW-1:0];
    end
    if (cmd_i.cap_sum) begin
      rsum_q <= rx_byte_i;
    end
    if (cmd_i.out_load) begin
      kind_q  <= cmd_i.out_kind;
      ocmd_q  <= cmd_q;
      olen_q  <= len_q;
      obyte_q <= (cmd_i.out_kind == KIND_PAY) ? rd_q : '0;
      olast_q <= last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign sts_o.is_start   = (rx_byte_i == StartByte);
  assign sts_o.is_sync    = (rx_byte_i == SyncByte);
  assign sts_o.is_trailer = (rx_byte_i == TrailerByte);
  assign sts_o.is_zero    = (rx_byte_i == '0);
  assign sts_o.too_long   = (rx_byte_i > ByteW'(MaxPayload));
  assign sts_o.body_last  = (cnt_inc == LenW'(len_q));
  assign sts_o.sum_ok     = (sum_q == rsum_q);
  assign sts_o.pay_last   = (cnt_inc == LenW'(len_q));
  assign sts_o.out_free   = out_free;

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign command_o        = ocmd_q;
  assign payload_length_o = olen_q;
  assign payload_byte_o   = obyte_q;
  assign last_o           = olast_q;

endmodule

// ===== hw/rtl/scfp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial command frame parser checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "serial_command_frame_parser_defines.svh"

module scfp_checker import scfp_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [1:0]           kind_o,
  input logic [ByteW-1:0]     command_o,
  input logic [LenFieldW-1:0] payload_length_o,
  input logic [ByteW-1:0]     payload_byte_o,
  input logic                 last_o
);

  `SCFP_ASSERT(a_stall_hold, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(kind_o) && $stable(command_o) && $stable(payload_length_o) && $stable(payload_byte_o) && $stable(last_o)), "stalled result request changed")
  `SCFP_ASSERT_IMPL(a_byte_zero, out_valid_o && kind_o != KIND_PAY, payload_byte_o == '0, "payload byte set outside a payload result")
  `SCFP_ASSERT_IMPL(a_single_last, out_valid_o && (kind_o == KIND_READ || kind_o == KIND_ERR), last_o, "read or checksum-error result not marked last")
  `SCFP_ASSERT_IMPL(a_hdr_body, out_valid_o && kind_o == KIND_HDR, !last_o && payload_length_o != '0, "write header without payload to follow")

endmodule

bind serial_command_frame_parser scfp_checker u_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .kind_o           (kind_o),
  .command_o        (command_o),
  .payload_length_o (payload_length_o),
  .payload_byte_o   (payload_byte_o),
  .last_o           (last_o)
);

// ===== dv/serial_command_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial command frame checker
// Watches both channels of the frame parser. Every accepted byte is parsed
// by a local frame decoder that queues the results it implies. Every
// accepted result is checked field by field against the oldest queued one.
// ----------------------------------------------------------------------------
module serial_command_frame_checker import scfp_pkg::*; #(
  parameter int MaxPayload = MaxPayloadDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [ByteW-1:0]     rx_byte_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [1:0]           kind_i,
  input  logic [ByteW-1:0]     command_i,
  input  logic [LenFieldW-1:0] payload_length_i,
  input  logic [ByteW-1:0]     payload_byte_i,
  input  logic                 last_i,
  output int                   mismatches_o,
  output int                   outstanding_o
);

  typedef enum logic [2:0] {
    HUNT_START  = 3'd0,
    WAIT_SYNC   = 3'd1,
    TAKE_CMD    = 3'd2,
    TAKE_LEN    = 3'd3,
    READ_TAIL   = 3'd4,
    WRITE_BODY  = 3'd5
  } parse_state_e;

  typedef struct packed {
    kind_e                kind;
    logic [ByteW-1:0]     command;
    logic [LenFieldW-1:0] length;
    logic [ByteW-1:0]     pbyte;
    logic                 last;
  } frame_result_t;

  parse_state_e         parse_state;
  logic [ByteW-1:0]     frame_command;
  logic [LenFieldW-1:0] frame_length;
  logic [6:0]           bytes_left;
  logic [ByteW-1:0]     running_sum;
  logic [ByteW-1:0]     received_sum;
  logic [LenFieldW-1:0] write_index;
  logic [ByteW-1:0]     payload_store [MaxPayload];

  frame_result_t expected_results [$];
  int            mismatch_count = 0;

  assign mismatches_o = mismatch_count;

  initial outstanding_o = 0;

  function automatic void queue_result(input kind_e kind, input logic [LenFieldW-1:0] length,
                                       input logic [ByteW-1:0] pbyte, input logic last);
    frame_result_t r;
    r.kind    = kind;
    r.command = frame_command;
    r.length  = length;
    r.pbyte   = pbyte;
    r.last    = last;
    expected_results.push_back(r);
  endfunction

  function automatic void parse_rx_byte(input logic [ByteW-1:0] b);
    int i;
    case (parse_state)
      HUNT_START: begin
        if (b == StartByte) parse_state = WAIT_SYNC;
      end
      WAIT_SYNC: begin
        parse_state = (b == SyncByte) ? TAKE_CMD : HUNT_START;
      end
      TAKE_CMD: begin
        frame_command = b;
        parse_state   = TAKE_LEN;
      end
      TAKE_LEN: begin
        if (b > MaxPayload) begin
          parse_state = HUNT_START;
        end else if (b == 0) begin
          frame_length = '0;
          bytes_left   = 7'd1;
          parse_state  = READ_TAIL;
        end else begin
          frame_length = b[LenFieldW-1:0];
          bytes_left   = 7'(b + 2);
          running_sum  = '0;
          received_sum = '0;
          write_index  = '0;
          parse_state  = WRITE_BODY;
        end
      end
      READ_TAIL: begin
        if (bytes_left == 7'd1) begin
          bytes_left = '0;
          if (b != 8'h00) parse_state = HUNT_START;
        end else begin
          if (b == TrailerByte) queue_result(KIND_READ, '0, '0, 1'b1);
          parse_state = HUNT_START;
        end
      end
      WRITE_BODY: begin
        if (bytes_left > 7'd2) begin
          running_sum = running_sum + b;
          if (write_index < MaxPayload) begin
            payload_store[write_index] = b;
            write_index = write_index + 1'b1;
          end
        end else if (bytes_left == 7'd2) begin
          received_sum = b;
        end
        if (bytes_left > 0) bytes_left = bytes_left - 1'b1;
        if (bytes_left == 0) begin
          parse_state = HUNT_START;
          if (running_sum != received_sum) begin
            queue_result(KIND_ERR, frame_length, '0, 1'b1);
          end else if (b == TrailerByte) begin
            queue_result(KIND_HDR, frame_length, '0, frame_length == 0);
            for (i = 0; i < frame_length && i < MaxPayload; i++) begin
              queue_result(KIND_PAY, frame_length, payload_store[i], i + 1 == frame_length);
            end
          end
        end
      end
      default: begin
        parse_state = HUNT_START;
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    frame_result_t want;
    if (!rst_ni) begin
      parse_state   = HUNT_START;
      frame_command = '0;
      frame_length  = '0;
      bytes_left    = '0;
      running_sum   = '0;
      received_sum  = '0;
      write_index   = '0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("unexpected result: kind %0d command %h length %0d byte %h last %0b",
                     kind_i, command_i, payload_length_i, payload_byte_i, last_i);
          end
        end else begin
          want = expected_results.pop_front();
          if (kind_i !== want.kind || command_i !== want.command ||
              payload_length_i !== want.length || payload_byte_i !== want.pbyte ||
              last_i !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("result mismatch (expected/actual): kind %0d/%0d command %h/%h",
                       want.kind, kind_i, want.command, command_i);
              $display("  length %0d/%0d byte %h/%h last %0b/%0b",
                       want.length, payload_length_i, want.pbyte, payload_byte_i,
                       want.last, last_i);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) parse_rx_byte(rx_byte_i);
      outstanding_o = expected_results.size();
    end
  end

endmodule

// ===== dv/serial_command_frame_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial command frame parser testbench
// Feeds directed and random byte streams made of read, write and broken
// frames plus noise, under changing idle and stall patterns, and reports
// the verdict of the frame checker.
// ----------------------------------------------------------------------------
module serial_command_frame_parser_tb import scfp_pkg::*;;

  localparam int Limit       = 300000;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 100;
  localparam int PhaseBytes  = 4;

  localparam int FILL_RANDOM = 0;
  localparam int FILL_ZERO   = 1;
  localparam int FILL_ONES   = 2;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [ByteW-1:0]     rx_byte_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [1:0]           kind_o;
  logic [ByteW-1:0]     command_o;
  logic [LenFieldW-1:0] payload_length_o;
  logic [ByteW-1:0]     payload_byte_o;
  logic                 last_o;

  int mismatches;
  int outstanding;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int unsigned rx_count = 0;
  int unsigned cycle_count = 0;
  bit hold_req = 1'b0;

  serial_command_frame_parser u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .command_o        (command_o),
    .payload_length_o (payload_length_o),
    .payload_byte_o   (payload_byte_o),
    .last_o           (last_o)
  );

  serial_command_frame_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_i           (kind_o),
    .command_i        (command_o),
    .payload_length_i (payload_length_o),
    .payload_byte_i   (payload_byte_o),
    .last_i           (last_o),
    .mismatches_o     (mismatches),
    .outstanding_o    (outstanding)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= Limit) begin
      $display("serial_command_frame_parser verification failed");
      $finish;
    end
  end

  // The receiver can be told to hold off for a long stretch while requests keep coming.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    rx_count++;
    @(negedge clk_i);
  endtask

  task automatic send_frame(input logic [ByteW-1:0] second, input logic [ByteW-1:0] cmd,
                            input logic [ByteW-1:0] len_byte, input int fill,
                            input logic [ByteW-1:0] sum_delta,
                            input logic [ByteW-1:0] trailer);
    logic [ByteW-1:0] sum;
    logic [ByteW-1:0] b;
    int               count;
    sum   = '0;
    count = (len_byte > MaxPayloadDef) ? 2 : int'(len_byte);
    send_byte(StartByte);
    send_byte(second);
    send_byte(cmd);
    send_byte(len_byte);
    for (int i = 0; i < count; i++) begin
      b = (fill == FILL_ZERO) ? 8'h00 : (fill == FILL_ONES) ? 8'hFF : 8'($urandom);
      sum = sum + b;
      send_byte(b);
    end
    send_byte(sum + sum_delta);
    send_byte(trailer);
  endtask

  task automatic send_random_frame();
    int pick;
    int len;
    pick = $urandom_range(99);
    len  = ($urandom_range(9) == 0) ? $urandom_range(MaxPayloadDef, 20) : $urandom_range(8, 1);
    if (pick < 60) begin
      send_frame(SyncByte, 8'($urandom), 8'(len), FILL_RANDOM, 8'h00, TrailerByte);
    end else if (pick < 72) begin
      send_frame(SyncByte, 8'($urandom), 8'h00, FILL_RANDOM, 8'h00, TrailerByte);
    end else if (pick < 80) begin
      send_frame(SyncByte, 8'($urandom), 8'(len), FILL_RANDOM, 8'($urandom_range(255, 1)),
                 ($urandom_range(1) == 0) ? TrailerByte : 8'($urandom));
    end else if (pick < 85) begin
      send_frame(SyncByte, 8'($urandom), ($urandom_range(1) == 0) ? 8'(len) : 8'h00,
                 FILL_RANDOM, 8'h00, 8'($urandom));
    end else if (pick < 88) begin
      send_frame(8'($urandom), 8'($urandom), 8'(len), FILL_RANDOM, 8'h00, TrailerByte);
    end else if (pick < 92) begin
      send_frame(SyncByte, 8'($urandom), 8'($urandom_range(255, MaxPayloadDef + 1)),
                 FILL_RANDOM, 8'h00, TrailerByte);
    end else if (pick < 95) begin
      send_frame(SyncByte, 8'($urandom), 8'h00, FILL_RANDOM, 8'($urandom_range(255, 1)),
                 TrailerByte);
    end else begin
      repeat ($urandom_range(6, 1)) send_byte(8'($urandom));
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
  endtask

  initial begin
    int unsigned phase_start;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    rx_byte_i  = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_frame(SyncByte, 8'h00, 8'h00, FILL_RANDOM, 8'h00, TrailerByte);
    send_frame(SyncByte, 8'hFF, 8'h00, FILL_RANDOM, 8'h00, TrailerByte);
    send_frame(SyncByte, 8'h5A, 8'h01, FILL_ONES, 8'h00, TrailerByte);
    send_frame(SyncByte, 8'h11, 8'h02, FILL_ZERO, 8'h00, TrailerByte);
    send_frame(SyncByte, 8'h22, 8'h03, FILL_RANDOM, 8'h01, TrailerByte);
    send_frame(SyncByte, 8'h33, 8'h04, FILL_RANDOM, 8'h80, 8'h00);
    send_frame(SyncByte, 8'h44, 8'h05, FILL_RANDOM, 8'h00, 8'hFF);
    send_frame(SyncByte, 8'h55, 8'h00, FILL_RANDOM, 8'hFF, TrailerByte);
    send_frame(SyncByte, 8'h66, 8'h00, FILL_RANDOM, 8'h00, StartByte);
    // A doubled start byte drops the frame without restarting on the second one.
    send_byte(StartByte);
    send_frame(SyncByte, 8'h77, 8'h00, FILL_RANDOM, 8'h00, TrailerByte);
    send_frame(8'h02, 8'h88, 8'h01, FILL_RANDOM, 8'h00, TrailerByte);
    send_frame(SyncByte, 8'h99, 8'(MaxPayloadDef + 1), FILL_RANDOM, 8'h00, TrailerByte);
    send_frame(SyncByte, 8'hAA, 8'hFF, FILL_RANDOM, 8'h00, TrailerByte);
    wait_drained();

    // Long receiver hold-off while a full-size frame and a read frame arrive.
    hold_req = 1'b1;
    send_frame(SyncByte, 8'h5C, 8'(MaxPayloadDef), FILL_ONES, 8'h00, TrailerByte);
    send_frame(SyncByte, 8'h0F, 8'h00, FILL_RANDOM, 8'h00, TrailerByte);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = (p == 1) ? 84 : (p == 3) ? 9 : 0;
      recv_stall_pct = (p == 2) ? 84 : (p == 3) ? 9 : 0;
      phase_start = rx_count;
      while (rx_count - phase_start < PhaseBytes) send_random_frame();
    end
    in_valid_i <= 1'b0;

    while (outstanding != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("serial_command_frame_parser verification clean");
    end else begin
      $display("serial_command_frame_parser verification failed");
    end
    $finish;
  end

endmodule
